FILE: src/ansi_sgr_escape_parser_assert.svh
// assertion macros for the sgr escape parser
// used by ansi_sgr_escape_parser.sv, needs a clock and a reset in scope
`ifndef ANSI_SGR_ESCAPE_PARSER_ASSERT_SVH
`define ANSI_SGR_ESCAPE_PARSER_ASSERT_SVH

// condition holds in the same cycle
`define ASEP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the following cycle
`define ASEP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/asep_pkg.sv
// types and constants of the sgr escape parser
// no dependencies
package asep_pkg;

   localparam int CHAR_W  = 21;
   localparam int CODE_W  = 8;
   localparam int FG_W    = 5;
   localparam int BG_W    = 4;
   localparam int ATTR_W  = 13;
   localparam int REQ_DW  = 24;
   localparam int RSP_DW  = 48;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   typedef enum logic [1:0] {
      MODE_TEXT    = 2'd0,
      MODE_ESC     = 2'd1,
      MODE_PARAM   = 2'd2,
      MODE_AFTER_M = 2'd3
   } mode_type;

   localparam logic [CHAR_W-1:0] CH_ESC       = CHAR_W'(27);
   localparam logic [CHAR_W-1:0] CH_LBRACKET  = CHAR_W'(91);
   localparam logic [CHAR_W-1:0] CH_RBRACKET  = CHAR_W'(93);
   localparam logic [CHAR_W-1:0] CH_SEMICOLON = CHAR_W'(59);
   localparam logic [CHAR_W-1:0] CH_M         = CHAR_W'(109);
   localparam logic [CHAR_W-1:0] CH_DIGIT_0   = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] CH_DIGIT_9   = CHAR_W'(57);

   localparam logic [CODE_W-1:0] SGR_RESET      = 8'd0;
   localparam logic [CODE_W-1:0] SGR_BOLD       = 8'd1;
   localparam logic [CODE_W-1:0] SGR_ITALIC     = 8'd3;
   localparam logic [CODE_W-1:0] SGR_UNDERLINE  = 8'd4;
   localparam logic [CODE_W-1:0] SGR_BLINK_SLOW = 8'd5;
   localparam logic [CODE_W-1:0] SGR_BLINK_FAST = 8'd6;
   localparam logic [CODE_W-1:0] SGR_INVERSE    = 8'd7;
   localparam logic [CODE_W-1:0] SGR_CROSSED    = 8'd9;
   localparam logic [CODE_W-1:0] SGR_BOLD_OFF_A = 8'd21;
   localparam logic [CODE_W-1:0] SGR_BOLD_OFF_B = 8'd22;
   localparam logic [CODE_W-1:0] SGR_ITALIC_OFF = 8'd23;
   localparam logic [CODE_W-1:0] SGR_UNDER_OFF  = 8'd24;
   localparam logic [CODE_W-1:0] SGR_BLINK_OFF  = 8'd25;
   localparam logic [CODE_W-1:0] SGR_INV_OFF    = 8'd27;
   localparam logic [CODE_W-1:0] SGR_CROSS_OFF  = 8'd29;
   localparam logic [CODE_W-1:0] SGR_FG_FIRST   = 8'd30;
   localparam logic [CODE_W-1:0] SGR_FG_LAST    = 8'd37;
   localparam logic [CODE_W-1:0] SGR_FG_DEFAULT = 8'd39;
   localparam logic [CODE_W-1:0] SGR_BG_FIRST   = 8'd40;
   localparam logic [CODE_W-1:0] SGR_BG_LAST    = 8'd47;
   localparam logic [CODE_W-1:0] SGR_BG_DEFAULT = 8'd49;
   localparam logic [CODE_W-1:0] CODE_SAT       = 8'd255;
   localparam logic [CODE_W-1:0] CODE_LIMIT_RST = 8'd50;

   localparam logic [FG_W-1:0] FG_NORMAL_BASE = 5'd1;
   localparam logic [FG_W-1:0] FG_BOLD_BASE   = 5'd9;
   localparam logic [FG_W-1:0] FG_DEFAULT     = 5'd17;
   localparam logic [FG_W-1:0] FG_MAX         = 5'd17;
   localparam logic [BG_W-1:0] BG_BASE        = 4'd1;
   localparam logic [BG_W-1:0] BG_DEFAULT     = 4'd9;
   localparam logic [BG_W-1:0] BG_MAX         = 4'd9;

   localparam logic [ATTR_W-1:0] A_BOLD_ON    = 13'h0001;
   localparam logic [ATTR_W-1:0] A_BOLD_OFF   = 13'h0002;
   localparam logic [ATTR_W-1:0] A_ITAL_ON    = 13'h0004;
   localparam logic [ATTR_W-1:0] A_ITAL_OFF   = 13'h0008;
   localparam logic [ATTR_W-1:0] A_UND_ON     = 13'h0010;
   localparam logic [ATTR_W-1:0] A_UND_OFF    = 13'h0020;
   localparam logic [ATTR_W-1:0] A_BLINK_SLOW = 13'h0040;
   localparam logic [ATTR_W-1:0] A_BLINK_FAST = 13'h0080;
   localparam logic [ATTR_W-1:0] A_BLINK_OFF  = 13'h0100;
   localparam logic [ATTR_W-1:0] A_INV_ON     = 13'h0200;
   localparam logic [ATTR_W-1:0] A_INV_OFF    = 13'h0400;
   localparam logic [ATTR_W-1:0] A_CROSS_ON   = 13'h0800;
   localparam logic [ATTR_W-1:0] A_CROSS_OFF  = 13'h1000;

   localparam logic [CSR_AW-1:0] REG_CODE_LIMIT = 3'd0;

endpackage

FILE: src/ansi_sgr_escape_parser.sv
// sgr escape parser top level: decode of one character per beat, state and result register
// depends on asep_pkg and ansi_sgr_escape_parser_assert.svh
//
//   channel  dir   beat contents
//   req_     in    tdata: char_code; tuser: start_of_text
//   rsp_     out   tdata: glyph, fg_color, bg_color, attributes
//   csr_     apb   code_limit at byte address 0
//
// one character per cycle unless rsp stalls: one decode step from state to result register
// a plain character shows on rsp the cycle after its req beat; others give no beat
// reset: parser in text mode, colors and marks cleared, code_limit 50
// req_tready stays high while the result register is empty or being drained
module ansi_sgr_escape_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [asep_pkg::REQ_DW-1:0]   req_tdata,   // [20:0] char_code, rest zero
   input  logic                          req_tuser,   // [0] start_of_text
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [20:0] glyph, [25:21] fg_color, [29:26] bg_color, [42:30] attributes, rest zero
   output logic [asep_pkg::RSP_DW-1:0]   rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [asep_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [asep_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [asep_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import asep_pkg::*;
   `include "ansi_sgr_escape_parser_assert.svh"

   logic [CODE_W-1:0] code_limit_ff;
   mode_type          mode_ff, mode_in, cur_mode;
   logic [CODE_W-1:0] code_ff, code_in, cur_code;
   logic              done_ff, done_in, cur_done;
   logic              bold_ff, bold_in, cur_bold;
   logic [FG_W-1:0]   fg_ff, fg_in, cur_fg;
   logic [BG_W-1:0]   bg_ff, bg_in, cur_bg;
   logic [ATTR_W-1:0] attr_ff, attr_in, cur_attr;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0] rsp_data_ff, rsp_data_in;

   logic [CHAR_W-1:0] ch;
   logic              req_fire, csr_write;
   logic              text_path, apply_req, abort, emit, is_digit;
   logic [11:0]       digit_sum;

   assign ch        = req_tdata[CHAR_W-1:0];
   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == REG_CODE_LIMIT[CSR_AW-1:2])
                       ? CSR_DW'(code_limit_ff) : '0;

   // start of text clears the state seen by this character
   always_comb begin
      if (req_tuser) begin
         cur_mode = MODE_TEXT;
         cur_code = '0;
         cur_done = 1'b0;
         cur_bold = 1'b0;
         cur_fg   = '0;
         cur_bg   = '0;
         cur_attr = '0;
      end else begin
         cur_mode = mode_ff;
         cur_code = code_ff;
         cur_done = done_ff;
         cur_bold = bold_ff;
         cur_fg   = fg_ff;
         cur_bg   = bg_ff;
         cur_attr = attr_ff;
      end
   end

   assign abort     = cur_code >= code_limit_ff;
   assign is_digit  = (ch >= CH_DIGIT_0) && (ch <= CH_DIGIT_9);
   assign digit_sum = {4'd0, cur_code} * 12'd10 + {8'd0, ch[3:0]};

   // next state
   always_comb begin
      mode_in   = cur_mode;
      code_in   = cur_code;
      done_in   = cur_done;
      bold_in   = cur_bold;
      fg_in     = cur_fg;
      bg_in     = cur_bg;
      attr_in   = cur_attr;
      text_path = 1'b0;
      apply_req = 1'b0;
      case (cur_mode)
         MODE_ESC: begin
            if (ch == CH_LBRACKET) begin
               mode_in = MODE_PARAM;
               code_in = '0;
               done_in = 1'b0;
            end else begin
               text_path = 1'b1;
            end
         end
         MODE_PARAM: begin
            if (ch == CH_SEMICOLON) begin
               apply_req = 1'b1;
               mode_in   = abort ? MODE_TEXT : MODE_PARAM;
            end else if (ch == CH_M) begin
               apply_req = 1'b1;
               mode_in   = MODE_AFTER_M;
            end else if (ch == CH_RBRACKET) begin
               apply_req = 1'b1;
               mode_in   = MODE_TEXT;
            end else if (is_digit) begin
               if (!cur_done) begin
                  code_in = (digit_sum > 12'(CODE_SAT)) ? CODE_SAT : digit_sum[CODE_W-1:0];
               end
            end else begin
               done_in = 1'b1;
            end
         end
         MODE_AFTER_M: begin
            if (ch == CH_RBRACKET) begin
               mode_in = MODE_TEXT;
            end else begin
               text_path = 1'b1;
            end
         end
         default: begin
            text_path = 1'b1;
         end
      endcase

      if (text_path) begin
         mode_in = MODE_TEXT;
         if (ch == CH_ESC) begin
            mode_in = MODE_ESC;
            bold_in = 1'b0;
         end
      end

      if (apply_req) begin
         code_in = '0;
         done_in = 1'b0;
         if (!abort) begin
            case (cur_code) inside
               SGR_RESET: begin
                  fg_in   = '0;
                  bg_in   = '0;
                  attr_in = '0;
                  bold_in = 1'b0;
               end
               SGR_BOLD: begin
                  attr_in = (cur_attr & ~A_BOLD_OFF) | A_BOLD_ON;
                  bold_in = 1'b1;
               end
               SGR_ITALIC:     attr_in = (cur_attr & ~A_ITAL_OFF) | A_ITAL_ON;
               SGR_UNDERLINE:  attr_in = (cur_attr & ~A_UND_OFF) | A_UND_ON;
               SGR_BLINK_SLOW: attr_in = (cur_attr & ~A_BLINK_OFF) | A_BLINK_SLOW;
               SGR_BLINK_FAST: attr_in = (cur_attr & ~A_BLINK_OFF) | A_BLINK_FAST;
               SGR_INVERSE:    attr_in = (cur_attr & ~A_INV_OFF) | A_INV_ON;
               SGR_CROSSED:    attr_in = (cur_attr & ~A_CROSS_OFF) | A_CROSS_ON;
               SGR_BOLD_OFF_A, SGR_BOLD_OFF_B: begin
                  attr_in = (cur_attr & ~A_BOLD_ON) | A_BOLD_OFF;
                  bold_in = 1'b0;
               end
               SGR_ITALIC_OFF: attr_in = (cur_attr & ~A_ITAL_ON) | A_ITAL_OFF;
               SGR_UNDER_OFF:  attr_in = (cur_attr & ~A_UND_ON) | A_UND_OFF;
               SGR_BLINK_OFF: begin
                  attr_in = (cur_attr & ~(A_BLINK_SLOW | A_BLINK_FAST)) | A_BLINK_OFF;
               end
               SGR_INV_OFF:    attr_in = (cur_attr & ~A_INV_ON) | A_INV_OFF;
               SGR_CROSS_OFF:  attr_in = (cur_attr & ~A_CROSS_ON) | A_CROSS_OFF;
               [SGR_FG_FIRST:SGR_FG_LAST]: begin
                  if (cur_bold) begin
                     attr_in = cur_attr & ~A_BOLD_ON;
                     fg_in   = FG_BOLD_BASE + FG_W'(cur_code - SGR_FG_FIRST);
                  end else begin
                     fg_in   = FG_NORMAL_BASE + FG_W'(cur_code - SGR_FG_FIRST);
                  end
               end
               SGR_FG_DEFAULT: fg_in = FG_DEFAULT;
               [SGR_BG_FIRST:SGR_BG_LAST]: bg_in = BG_BASE + BG_W'(cur_code - SGR_BG_FIRST);
               SGR_BG_DEFAULT: bg_in = BG_DEFAULT;
               default: ;
            endcase
         end
      end
   end

   // result
   always_comb begin
      emit        = text_path && (ch != CH_ESC);
      rsp_data_in = {5'd0, cur_attr, cur_bg, cur_fg, ch};
      if (req_fire) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_limit_ff <= CODE_LIMIT_RST;
         mode_ff       <= MODE_TEXT;
         code_ff       <= '0;
         done_ff       <= 1'b0;
         bold_ff       <= 1'b0;
         fg_ff         <= '0;
         bg_ff         <= '0;
         attr_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write && csr_paddr[CSR_AW-1:2] == REG_CODE_LIMIT[CSR_AW-1:2]) begin
            code_limit_ff <= csr_pwdata[CODE_W-1:0];
         end
         if (req_fire) begin
            mode_ff <= mode_in;
            code_ff <= code_in;
            done_ff <= done_in;
            bold_ff <= bold_in;
            fg_ff   <= fg_in;
            bg_ff   <= bg_in;
            attr_ff <= attr_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASEP_ASSERT_NOW(a_esc_clears_bold, mode_ff == MODE_ESC, !bold_ff, "bold flag set after escape")
   `ASEP_ASSERT_NOW(a_color_range, 1'b1, fg_ff <= FG_MAX && bg_ff <= BG_MAX, "color out of range")
   `ASEP_ASSERT_NOW(a_mark_pairs, 1'b1, !(attr_ff[0] && attr_ff[1]) && !(attr_ff[6] && attr_ff[8]), "on and off marks both set")
   `ASEP_ASSERT_NEXT(a_esc_enters, req_fire && text_path && ch == CH_ESC, mode_ff == MODE_ESC, "escape not taken")
   `ASEP_ASSERT_NEXT(a_emit_shows, req_fire && emit, rsp_valid_ff && rsp_data_ff[CHAR_W-1:0] == $past(ch), "plain character lost")

endmodule
